// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/rsema_pkg.sv =====
// Package for the RSSI EMA mean/variance/trend filter: widths, codes,
// shared arithmetic unit request type. No dependencies.
package rsema_pkg;

    localparam int DB_FRAC_BITS = 4;

    localparam int MODE_W    = 2;
    localparam int SAMPLE_W  = 13;
    localparam int TIME_W    = 32;
    localparam int MEAN_W    = 13;
    localparam int VAR_W     = 26;
    localparam int STD_W     = 17;
    localparam int TREND_W   = 28;
    localparam int CNT_W     = 16;
    localparam int ALPHA_W   = 16;
    localparam int MINS_W    = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // ms -> s and dB fraction scaling of the trend numerator
    localparam int TREND_SCALE = 1000 * (1 << DB_FRAC_BITS);

    localparam logic [MODE_W-1:0] MODE_SAMPLE = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_AGE    = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_CLEAR  = MODE_W'(2);

    // shared unit: MUL is a[MUL_A_W-1:0] * b[MUL_B_W-1:0], SUB is a - b with borrow
    localparam int MUL_A_W  = 32;
    localparam int MUL_B_W  = 18;
    localparam int UNIT_A_W = 34;
    localparam int UNIT_Y_W = MUL_A_W + MUL_B_W;

    typedef enum logic {
        UOP_MUL,
        UOP_SUB
    } t_unit_op;

    typedef struct packed {
        t_unit_op              op;
        logic [UNIT_A_W-1:0]   a;
        logic [UNIT_A_W-1:0]   b;
    } t_unit_req;

endpackage

// ===== rtl/rsema_if.sv =====
// Valid/ready channel interfaces for the RSSI filter: input items and results.
// Depends on rsema_pkg.
interface rsema_in_if;
    import rsema_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [MODE_W-1:0]           mode;
    logic signed [SAMPLE_W-1:0]  sample_dbm;
    logic [TIME_W-1:0]           now_ms;

    modport source (output valid, output mode, output sample_dbm, output now_ms,
                    input ready);
    modport sink   (input valid, input mode, input sample_dbm, input now_ms,
                    output ready);
endinterface

interface rsema_out_if;
    import rsema_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [MEAN_W-1:0]    mean_dbm;
    logic [VAR_W-1:0]            variance_db2;
    logic [STD_W-1:0]            std_db;
    logic signed [TREND_W-1:0]   trend_db_per_s;
    logic [CNT_W-1:0]            sample_count;
    logic                        usable;
    logic                        seeded;

    modport source (output valid, output mean_dbm, output variance_db2, output std_db,
                    output trend_db_per_s, output sample_count, output usable,
                    output seeded, input ready);
    modport sink   (input valid, input mean_dbm, input variance_db2, input std_db,
                    input trend_db_per_s, input sample_count, input usable,
                    input seeded, output ready);
endinterface

// ===== rtl/rsema_unit.sv =====
// Shared arithmetic unit: one unsigned multiplier and one subtract/compare.
// Depends on rsema_pkg.
module rsema_unit (
    input  rsema_pkg::t_unit_req              i_req,
    output logic [rsema_pkg::UNIT_Y_W-1:0]    o_y
);
    import rsema_pkg::*;

    logic [UNIT_Y_W-1:0]  w_prod;
    logic [UNIT_A_W:0]    w_diff;

    assign w_prod = i_req.a[MUL_A_W-1:0] * i_req.b[MUL_B_W-1:0];
    // MSB of w_diff is the borrow (a < b)
    assign w_diff = {1'b0, i_req.a} - {1'b0, i_req.b};

    always_comb begin
        case (i_req.op)
            UOP_MUL: o_y = w_prod;
            UOP_SUB: o_y = {{(UNIT_Y_W-UNIT_A_W-1){1'b0}}, w_diff};
            default: o_y = '0;
        endcase
    end

endmodule

// ===== rtl/rssi_ema_mean_variance_trend.sv =====
// RSSI filter top level: exponential mean, variance, trend and deviation.
// Depends on rsema_pkg, rsema_if, rsema_unit and assert_macros.svh.
//
// One transaction in gives one transaction out. The block takes one item at a
// time and deasserts ready while it works; a finished result sits in the output
// register, so the next item is taken as soon as the sequencer is back in idle.
// Paths from accept to result: age check or clear goes straight to the output
// register; the first sample of an unseeded filter runs only the square root; a
// later sample also updates mean and variance, and with nonzero elapsed time the
// trend too. The long path is set by the bit-serial trend divider (33 steps, one
// quotient bit per cycle) and the 13-step square root, both running on the single
// shared multiply/subtract unit. Mean and variance use five multiplies on the
// same unit; the 43 x 17 variance product is split into two partial products.
// Configuration is a plain write port, taken at any edge with i_cfg_we high.
`include "assert_macros.svh"

module rssi_ema_mean_variance_trend (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rsema_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rsema_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rsema_in_if.sink                          i_in,
    rsema_out_if.source                       o_out
);
    import rsema_pkg::*;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_ALPHA  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TREND_ALPHA = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_VAR    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE     = CFG_IDX_W'(4);

    localparam logic [ALPHA_W-1:0] MEAN_ALPHA_RST  = ALPHA_W'(13107);
    localparam logic [ALPHA_W-1:0] TREND_ALPHA_RST = ALPHA_W'(19661);
    localparam logic [VAR_W-1:0]   BOOT_VAR_RST    = VAR_W'(9216);
    localparam logic [MINS_W-1:0]  MIN_SAMPLES_RST = MINS_W'(3);
    localparam logic [TIME_W-1:0]  MAX_AGE_RST     = TIME_W'(10000);

    localparam logic signed [MEAN_W-1:0]  MEAN_MAX  = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic signed [MEAN_W-1:0]  MEAN_MIN  = {1'b1, {(MEAN_W-1){1'b0}}};
    localparam logic signed [TREND_W-1:0] TREND_MAX = {1'b0, {(TREND_W-1){1'b1}}};
    localparam logic signed [TREND_W-1:0] TREND_MIN = {1'b1, {(TREND_W-1){1'b0}}};
    localparam logic [VAR_W-1:0]          VAR_MAX   = '1;

    localparam int SQRT_W    = VAR_W / 2;        // width of the root
    localparam int DIV_STEPS = TIME_W + 1;       // dividend bits
    localparam logic [VAR_W-2:0] SQRT_BIT0 = (VAR_W-1)'(1) << (VAR_W - 2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MMUL,     // |delta| * mean_alpha
        S_MEAN,     // new mean, |delta|^2
        S_D2A,      // delta^2 * mean_alpha
        S_INNER,    // (var << 16) + delta^2 * alpha
        S_PLO,      // inner low word * (1 - alpha)
        S_PHI,      // inner high bits * (1 - alpha), round low part
        S_VAR,      // new variance, time and count
        S_TMUL,     // |mean change| * 1000 * 2^F
        S_DINIT,    // rounding bias, divider setup
        S_DIV,      // one quotient bit per cycle
        S_TDIFF,    // raw rate - trend
        S_TMUL2,    // |diff| * trend_alpha
        S_TREND,    // new trend
        S_SQRT,     // one root bit per cycle
        S_FINISH    // hand result to output register
    } t_state;

    t_state                      r_state;

    // configuration
    logic [ALPHA_W-1:0]          r_mean_alpha;
    logic [ALPHA_W-1:0]          r_trend_alpha;
    logic [VAR_W-1:0]            r_boot_var;
    logic [MINS_W-1:0]           r_min_samples;
    logic [TIME_W-1:0]           r_max_age;

    // filter state
    logic                        r_seeded;
    logic [CNT_W-1:0]            r_count;
    logic [TIME_W-1:0]           r_last;
    logic signed [MEAN_W-1:0]    r_mean;
    logic [VAR_W-1:0]            r_var;
    logic signed [TREND_W-1:0]   r_trend;
    logic [SQRT_W-1:0]           r_std;

    // working registers
    logic [TIME_W-1:0]           r_now;
    logic [TIME_W-1:0]           r_elapsed;
    logic signed [MEAN_W:0]      r_delta;
    logic signed [MEAN_W-1:0]    r_old_mean;
    logic [UNIT_Y_W-1:0]         r_acc;
    logic [MUL_B_W-1:0]          r_carry;
    logic [VAR_W+ALPHA_W:0]      r_inner;
    logic [DIV_STEPS-1:0]        r_quo;
    logic [TIME_W-1:0]           r_rem;
    logic [5:0]                  r_cnt;
    logic signed [TREND_W:0]     r_tdiff;
    logic [VAR_W-1:0]            r_sx;
    logic [VAR_W:0]              r_sres;
    logic [VAR_W-2:0]            r_sbit;

    // output register
    logic                        r_out_valid;
    logic signed [MEAN_W-1:0]    r_o_mean;
    logic [VAR_W-1:0]            r_o_var;
    logic [SQRT_W-1:0]           r_o_std;
    logic signed [TREND_W-1:0]   r_o_trend;
    logic [CNT_W-1:0]            r_o_count;
    logic                        r_o_usable;
    logic                        r_o_seeded;

    // shared unit
    t_unit_req                   w_req;
    logic [UNIT_Y_W-1:0]         w_unit_y;
    logic                        w_borrow;

    logic                        w_accept;
    logic signed [MEAN_W:0]      w_delta_in;
    logic [MEAN_W:0]             w_delta_mag;
    logic [MEAN_W:0]             w_qm;
    logic signed [MEAN_W+1:0]    w_mean_sum;
    logic signed [MEAN_W-1:0]    w_mean_new;
    logic [ALPHA_W:0]            w_comp;
    logic [VAR_W+2:0]            w_var_sum;
    logic [VAR_W-1:0]            w_var_new;
    logic signed [MEAN_W:0]      w_dmean;
    logic [MEAN_W:0]             w_dmean_mag;
    logic [DIV_STEPS-1:0]        w_rem_sh;
    logic signed [TREND_W-1:0]   w_raw;
    logic [TREND_W:0]            w_tdiff_mag;
    logic [TREND_W:0]            w_qt;
    logic signed [TREND_W+1:0]   w_trend_sum;
    logic signed [TREND_W-1:0]   w_trend_new;
    logic [VAR_W:0]              w_sqrt_sub;
    logic                        w_usable;

    rsema_unit u_unit (
        .i_req (w_req),
        .o_y   (w_unit_y)
    );

    assign w_borrow = w_unit_y[UNIT_A_W];
    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // mean update
    assign w_delta_in  = (MEAN_W+1)'(i_in.sample_dbm) - (MEAN_W+1)'(r_mean);
    assign w_delta_mag = r_delta[MEAN_W] ? (MEAN_W+1)'(-r_delta) : (MEAN_W+1)'(r_delta);
    assign w_qm        = (MEAN_W+1)'((31'(r_acc[29:0]) + 31'd32768) >> ALPHA_W);
    assign w_mean_sum  = (MEAN_W+2)'(r_mean)
                       + (r_delta[MEAN_W] ? -$signed({1'b0, w_qm}) : $signed({1'b0, w_qm}));
    assign w_mean_new  = (w_mean_sum > (MEAN_W+2)'(MEAN_MAX)) ? MEAN_MAX :
                         (w_mean_sum < (MEAN_W+2)'(MEAN_MIN)) ? MEAN_MIN :
                         MEAN_W'(w_mean_sum);

    // variance update: complement of alpha is 65536 - alpha
    assign w_comp    = (ALPHA_W+1)'(1 << ALPHA_W) - (ALPHA_W+1)'(r_mean_alpha);
    assign w_var_sum = r_acc[VAR_W+2:0] + (VAR_W+3)'(r_carry);
    assign w_var_new = (w_var_sum > (VAR_W+3)'(VAR_MAX)) ? VAR_MAX : w_var_sum[VAR_W-1:0];

    // trend: rate of the mean in 1/256 dB per second; quotient stays below 2^27
    assign w_dmean     = (MEAN_W+1)'(r_mean) - (MEAN_W+1)'(r_old_mean);
    assign w_dmean_mag = w_dmean[MEAN_W] ? (MEAN_W+1)'(-w_dmean) : (MEAN_W+1)'(w_dmean);
    assign w_rem_sh    = {r_rem, r_quo[DIV_STEPS-1]};
    assign w_raw       = w_dmean[MEAN_W] ? -$signed({1'b0, r_quo[TREND_W-2:0]})
                                         :  $signed({1'b0, r_quo[TREND_W-2:0]});
    assign w_tdiff_mag = r_tdiff[TREND_W] ? (TREND_W+1)'(-r_tdiff) : (TREND_W+1)'(r_tdiff);
    assign w_qt        = (TREND_W+1)'((46'(r_acc[44:0]) + 46'd32768) >> ALPHA_W);
    assign w_trend_sum = (TREND_W+2)'(r_trend)
                       + (r_tdiff[TREND_W] ? -$signed({1'b0, w_qt}) : $signed({1'b0, w_qt}));
    assign w_trend_new = (w_trend_sum > (TREND_W+2)'(TREND_MAX)) ? TREND_MAX :
                         (w_trend_sum < (TREND_W+2)'(TREND_MIN)) ? TREND_MIN :
                         TREND_W'(w_trend_sum);

    // square root trial value
    assign w_sqrt_sub = r_sres + (VAR_W+1)'(r_sbit);

    // staleness at the item's own timestamp
    assign w_usable = r_seeded && (r_count >= CNT_W'(r_min_samples))
                   && ((r_now - r_last) <= r_max_age);

    // operand selection for the shared unit
    always_comb begin
        w_req.op = UOP_MUL;
        w_req.a  = '0;
        w_req.b  = '0;
        case (r_state)
            S_MMUL: begin
                w_req.a = UNIT_A_W'(w_delta_mag);
                w_req.b = UNIT_A_W'(r_mean_alpha);
            end
            S_MEAN: begin
                w_req.a = UNIT_A_W'(w_delta_mag);
                w_req.b = UNIT_A_W'(w_delta_mag);
            end
            S_D2A: begin
                w_req.a = UNIT_A_W'(r_acc[VAR_W:0]);
                w_req.b = UNIT_A_W'(r_mean_alpha);
            end
            S_PLO: begin
                w_req.a = UNIT_A_W'(r_inner[MUL_A_W-1:0]);
                w_req.b = UNIT_A_W'(w_comp);
            end
            S_PHI: begin
                w_req.a = UNIT_A_W'(r_inner[VAR_W+ALPHA_W:MUL_A_W]);
                w_req.b = UNIT_A_W'(w_comp);
            end
            S_TMUL: begin
                w_req.a = UNIT_A_W'(w_dmean_mag);
                w_req.b = UNIT_A_W'(TREND_SCALE);
            end
            S_DIV: begin
                w_req.op = UOP_SUB;
                w_req.a  = UNIT_A_W'(w_rem_sh);
                w_req.b  = UNIT_A_W'(r_elapsed);
            end
            S_TMUL2: begin
                w_req.a = UNIT_A_W'(w_tdiff_mag);
                w_req.b = UNIT_A_W'(r_trend_alpha);
            end
            S_SQRT: begin
                w_req.op = UOP_SUB;
                w_req.a  = UNIT_A_W'(r_sx);
                w_req.b  = UNIT_A_W'(w_sqrt_sub);
            end
            default: begin
                w_req.op = UOP_MUL;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean_alpha  <= MEAN_ALPHA_RST;
            r_trend_alpha <= TREND_ALPHA_RST;
            r_boot_var    <= BOOT_VAR_RST;
            r_min_samples <= MIN_SAMPLES_RST;
            r_max_age     <= MAX_AGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MEAN_ALPHA:  r_mean_alpha  <= i_cfg_data[ALPHA_W-1:0];
                CFG_TREND_ALPHA: r_trend_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_BOOT_VAR:    r_boot_var    <= i_cfg_data[VAR_W-1:0];
                CFG_MIN_SAMPLES: r_min_samples <= i_cfg_data[MINS_W-1:0];
                CFG_MAX_AGE:     r_max_age     <= i_cfg_data[TIME_W-1:0];
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // sequencer, filter state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seeded    <= 1'b0;
            r_count     <= '0;
            r_last      <= '0;
            r_mean      <= '0;
            r_var       <= '0;
            r_trend     <= '0;
            r_std       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drained result; S_FINISH refills in the same cycle on its own
            if (r_out_valid && o_out.ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_now     <= i_in.now_ms;
                        r_elapsed <= i_in.now_ms - r_last;
                        r_delta   <= w_delta_in;
                        case (i_in.mode)
                            MODE_SAMPLE: begin
                                if (!r_seeded) begin
                                    // first sample seeds everything
                                    r_seeded <= 1'b1;
                                    r_count  <= CNT_W'(1);
                                    r_last   <= i_in.now_ms;
                                    r_mean   <= i_in.sample_dbm;
                                    r_var    <= r_boot_var;
                                    r_trend  <= '0;
                                    r_sx     <= r_boot_var;
                                    r_sres   <= '0;
                                    r_sbit   <= SQRT_BIT0;
                                    r_state  <= S_SQRT;
                                end else begin
                                    r_state  <= S_MMUL;
                                end
                            end
                            MODE_CLEAR: begin
                                r_seeded <= 1'b0;
                                r_count  <= '0;
                                r_last   <= '0;
                                r_mean   <= '0;
                                r_var    <= '0;
                                r_trend  <= '0;
                                r_std    <= '0;
                                r_state  <= S_FINISH;
                            end
                            default: begin
                                // age check, unused code too
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_MMUL: begin
                    r_acc   <= w_unit_y;
                    r_state <= S_MEAN;
                end
                S_MEAN: begin
                    r_old_mean <= r_mean;
                    r_mean     <= w_mean_new;
                    r_acc      <= w_unit_y;
                    r_state    <= S_D2A;
                end
                S_D2A: begin
                    r_acc   <= w_unit_y;
                    r_state <= S_INNER;
                end
                S_INNER: begin
                    r_inner <= (VAR_W+ALPHA_W+1)'({r_var, {ALPHA_W{1'b0}}})
                             + (VAR_W+ALPHA_W+1)'(r_acc[VAR_W+ALPHA_W-1:0]);
                    r_state <= S_PLO;
                end
                S_PLO: begin
                    r_acc   <= w_unit_y;
                    r_state <= S_PHI;
                end
                S_PHI: begin
                    // round-half-up of the low word folds into a small carry
                    r_carry <= MUL_B_W'((49'(r_acc[48:0]) + 49'h0_8000_0000) >> MUL_A_W);
                    r_acc   <= w_unit_y;
                    r_state <= S_VAR;
                end
                S_VAR: begin
                    r_var  <= w_var_new;
                    r_sx   <= w_var_new;
                    r_sres <= '0;
                    r_sbit <= SQRT_BIT0;
                    r_last <= r_now;
                    if (r_count != '1) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_state <= (r_elapsed != '0) ? S_TMUL : S_SQRT;
                end
                S_TMUL: begin
                    r_acc   <= w_unit_y;
                    r_state <= S_DINIT;
                end
                S_DINIT: begin
                    r_quo   <= DIV_STEPS'(r_acc[TREND_W-2:0]) + DIV_STEPS'(r_elapsed >> 1);
                    r_rem   <= '0;
                    r_cnt   <= 6'(DIV_STEPS);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_borrow) begin
                        r_rem <= w_rem_sh[TIME_W-1:0];
                    end else begin
                        r_rem <= w_unit_y[TIME_W-1:0];
                    end
                    r_quo <= {r_quo[DIV_STEPS-2:0], ~w_borrow};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= S_TDIFF;
                    end
                end
                S_TDIFF: begin
                    r_tdiff <= (TREND_W+1)'(w_raw) - (TREND_W+1)'(r_trend);
                    r_state <= S_TMUL2;
                end
                S_TMUL2: begin
                    r_acc   <= w_unit_y;
                    r_state <= S_TREND;
                end
                S_TREND: begin
                    r_trend <= w_trend_new;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_sbit == '0) begin
                        r_std   <= r_sres[SQRT_W-1:0];
                        r_state <= S_FINISH;
                    end else begin
                        if (!w_borrow) begin
                            r_sx   <= w_unit_y[VAR_W-1:0];
                            r_sres <= (r_sres >> 1) + (VAR_W+1)'(r_sbit);
                        end else begin
                            r_sres <= r_sres >> 1;
                        end
                        r_sbit <= r_sbit >> 2;
                    end
                end
                S_FINISH: begin
                    // wait for the output register to free up
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_o_mean    <= r_mean;
                        r_o_var     <= r_var;
                        r_o_std     <= r_std;
                        r_o_trend   <= r_trend;
                        r_o_count   <= r_count;
                        r_o_usable  <= w_usable;
                        r_o_seeded  <= r_seeded;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.mean_dbm       = r_o_mean;
    assign o_out.variance_db2   = r_o_var;
    assign o_out.std_db         = STD_W'(r_o_std);
    assign o_out.trend_db_per_s = r_o_trend;
    assign o_out.sample_count   = r_o_count;
    assign o_out.usable         = r_o_usable;
    assign o_out.seeded         = r_o_seeded;

    // unseeded filter holds all-zero state
    `ASSERT_IMPLIES(a_unseeded_zero, i_clk, i_rst_n, !r_seeded, (r_count == '0) && (r_mean == '0) && (r_trend == '0) && (r_last == '0), "unseeded filter state not cleared")

    // a seeded filter has counted at least one sample
    `ASSERT_IMPLIES(a_seeded_count, i_clk, i_rst_n, r_seeded, r_count != '0, "seeded filter with zero count")

    // between items, the stored deviation is the floor root of the variance
    `ASSERT_IMPLIES(a_std_root, i_clk, i_rst_n, r_state == S_IDLE, ((40'(r_std) * 40'(r_std)) <= 40'(r_var)) && (((40'(r_std) + 40'd1) * (40'(r_std) + 40'd1)) > 40'(r_var)), "std does not match variance")

    // a clear transaction drops the seed and the deviation
    `ASSERT_NEXT(a_clear, i_clk, i_rst_n, w_accept && (i_in.mode == MODE_CLEAR), !r_seeded && (r_std == '0) && (r_var == '0), "clear did not reset filter")

endmodule
